// ----- hw/rtl/oil_pkg.sv -----
package oil_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// stream word layouts
	localparam int IN_W       = OP_W + DATA_W + POS_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = DATA_W + 1 + STAT_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd1;
	localparam logic [OP_W-1:0] OP_GET      = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_REVERSE  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_PAST = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RSVD = 2'd3;

	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// operation token that walks along the cell row, one cell a cycle
	typedef struct packed {
		logic                     active;
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         pos;
		logic [CNT_W-1:0]         cnt;
		logic [CNT_W-1:0]         idx;
		logic                     flag;
		logic signed [DATA_W-1:0] data;
	} tok_t;

	// row-wide controls for the reverse sequence
	typedef struct packed {
		logic shift;
		logic copy;
	} ctl_t;

endpackage

// ----- hw/rtl/ordered_integer_list_unit.sv -----
// Channel | Dir | Word fields (lowest bit up)
// s_*     | in  | opcode[2:0], operand_value[34:3], position[40:35]
// m_*     | out | read_value[31:0], found[32], status[34:33], entry_count[41:35]
//
// One word is taken at a time. Insert into a list that is not full, contains,
// and get or remove of a held position send a token down the row of CAPACITY
// cells, one cell a cycle. Reverse shifts the held entries through the cells'
// second registers. Every other word goes straight to the result. After reset
// the list is empty. A stalled result sits in the output register while the
// next word is accepted; the one after waits for it.
module ordered_integer_list_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// opcode, operand_value, position
	input  logic [oil_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// read_value, found, status, entry_count
	output logic [oil_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_WAVE, ST_REV, ST_DONE} state_t;

	state_t                                state_q;
	logic [oil_pkg::OP_W-1:0]              op_q;
	logic [oil_pkg::STAT_W-1:0]            st_q;
	logic                                  fnd_q;
	logic signed [oil_pkg::DATA_W-1:0]     rd_q;
	logic [oil_pkg::CNT_W-1:0]             cnt_q;
	logic [oil_pkg::CNT_W-1:0]             rev_q;
	logic                                  m_valid_q;
	logic [oil_pkg::OUT_TDATA_W-1:0]       m_data_q;

	logic [oil_pkg::OP_W-1:0]              in_op;
	logic signed [oil_pkg::DATA_W-1:0]     in_val;
	logic [oil_pkg::POS_W-1:0]             in_pos;
	logic                                  accept;
	logic                                  full;
	logic                                  pos_ok;
	logic                                  launch;
	logic                                  load;
	logic [oil_pkg::CNT_W-1:0]             cnt_new;
	logic signed [oil_pkg::DATA_W-1:0]     res_val;
	logic                                  res_fnd;

	oil_pkg::tok_t                         tok [oil_pkg::CAPACITY+1];
	oil_pkg::ctl_t                         ctl;
	logic signed [oil_pkg::DATA_W-1:0]     mains [oil_pkg::CAPACITY];
	logic signed [oil_pkg::DATA_W-1:0]     auxs  [oil_pkg::CAPACITY];

	// input word unpacking
	assign in_op  = s_tdata[oil_pkg::OP_W-1:0];
	assign in_val = s_tdata[oil_pkg::OP_W +: oil_pkg::DATA_W];
	assign in_pos = s_tdata[oil_pkg::OP_W + oil_pkg::DATA_W +: oil_pkg::POS_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == oil_pkg::CNT_W'(oil_pkg::CAPACITY));
	assign pos_ok   = oil_pkg::CMP_W'(in_pos) < oil_pkg::CMP_W'(cnt_q);

	// which operations need the token walk
	always_comb begin
		case (in_op)
			oil_pkg::OP_INSERT:                  launch = accept && !full;
			oil_pkg::OP_CONTAINS:                launch = accept;
			oil_pkg::OP_GET, oil_pkg::OP_REMOVE: launch = accept && pos_ok;
			default:                             launch = 1'b0;
		endcase
	end

	// token injected into the first cell
	assign tok[0] = {launch, in_op, in_val, in_pos, cnt_q,
		{oil_pkg::CNT_W{1'b0}}, 1'b0, {oil_pkg::DATA_W{1'b0}}};

	// reverse sequence: entry_count shifts, then one copy back
	always_comb begin
		ctl.shift = (state_q == ST_REV) && (rev_q != cnt_q);
		ctl.copy  = (state_q == ST_REV) && (rev_q == cnt_q);
	end

	// cell row
	for (genvar g = 0; g < oil_pkg::CAPACITY; g++) begin : g_cell
		logic signed [oil_pkg::DATA_W-1:0] right_w;
		logic signed [oil_pkg::DATA_W-1:0] left_w;
		if (g == oil_pkg::CAPACITY - 1) begin : g_end
			assign right_w = mains[g];
		end else begin : g_mid
			assign right_w = mains[g+1];
		end
		if (g == 0) begin : g_head
			assign left_w = mains[0];
		end else begin : g_body
			assign left_w = auxs[g-1];
		end
		oil_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok[g]),
			.tok_out    (tok[g+1]),
			.ctl        (ctl),
			.main_right (right_w),
			.main_out   (mains[g]),
			.aux_left   (left_w),
			.aux_out    (auxs[g])
		);
	end

	// result word and count after the operation
	always_comb begin
		cnt_new = cnt_q;
		if (st_q == oil_pkg::STAT_OK) begin
			if (op_q == oil_pkg::OP_INSERT) begin
				cnt_new = cnt_q + oil_pkg::CNT_W'(1);
			end else if (op_q == oil_pkg::OP_REMOVE) begin
				cnt_new = cnt_q - oil_pkg::CNT_W'(1);
			end
		end
		if (op_q == oil_pkg::OP_GET) begin
			res_val = (st_q == oil_pkg::STAT_PAST) ? oil_pkg::INT_MIN : rd_q;
		end else begin
			res_val = '0;
		end
		res_fnd = fnd_q && ((op_q == oil_pkg::OP_CONTAINS) || (op_q == oil_pkg::OP_GET));
	end

	assign load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= oil_pkg::OP_INSERT;
			st_q      <= oil_pkg::STAT_OK;
			fnd_q     <= 1'b0;
			rd_q      <= '0;
			cnt_q     <= '0;
			rev_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= in_op;
						st_q  <= oil_pkg::STAT_OK;
						fnd_q <= 1'b0;
						rev_q <= '0;
						case (in_op)
							oil_pkg::OP_INSERT: begin
								if (full) begin
									st_q    <= oil_pkg::STAT_FULL;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_WAVE;
								end
							end
							oil_pkg::OP_CONTAINS: state_q <= ST_WAVE;
							oil_pkg::OP_GET, oil_pkg::OP_REMOVE: begin
								if (pos_ok) begin
									state_q <= ST_WAVE;
								end else begin
									st_q    <= oil_pkg::STAT_PAST;
									state_q <= ST_DONE;
								end
							end
							oil_pkg::OP_REVERSE: state_q <= ST_REV;
							default:             state_q <= ST_DONE;
						endcase
					end
				end
				ST_WAVE: begin
					// token has left the last cell
					if (tok[oil_pkg::CAPACITY].active) begin
						fnd_q   <= tok[oil_pkg::CAPACITY].flag;
						rd_q    <= tok[oil_pkg::CAPACITY].data;
						state_q <= ST_DONE;
					end
				end
				ST_REV: begin
					if (rev_q == cnt_q) begin
						state_q <= ST_DONE;
					end else begin
						rev_q <= rev_q + oil_pkg::CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (load) begin
						cnt_q    <= cnt_new;
						m_data_q <= oil_pkg::OUT_TDATA_W'({oil_pkg::COUNT_W'(cnt_new),
							st_q, res_fnd, res_val});
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ----- hw/rtl/oil_cell.sv -----
module oil_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  oil_pkg::tok_t                    tok_in,
	output oil_pkg::tok_t                    tok_out,
	input  oil_pkg::ctl_t                    ctl,
	input  logic signed [oil_pkg::DATA_W-1:0] main_right,
	output logic signed [oil_pkg::DATA_W-1:0] main_out,
	input  logic signed [oil_pkg::DATA_W-1:0] aux_left,
	output logic signed [oil_pkg::DATA_W-1:0] aux_out
);

	logic signed [oil_pkg::DATA_W-1:0] main_q, main_d;
	logic signed [oil_pkg::DATA_W-1:0] aux_q, aux_d;
	oil_pkg::tok_t                     tok_q, tok_d;
	logic                              held;
	logic                              slot;
	logic                              at_pos;

	assign held   = tok_in.active && (tok_in.idx < tok_in.cnt);
	assign slot   = tok_in.active && (tok_in.idx == tok_in.cnt);
	assign at_pos = oil_pkg::CMP_W'(tok_in.idx) == oil_pkg::CMP_W'(tok_in.pos);

	// per-cell step: reverse shuffle, or the token's operation on this entry
	always_comb begin
		main_d    = main_q;
		aux_d     = aux_q;
		tok_d     = tok_in;
		tok_d.idx = tok_in.idx + oil_pkg::CNT_W'(1);
		if (ctl.shift) begin
			main_d = main_right;
			aux_d  = aux_left;
		end else if (ctl.copy) begin
			main_d = aux_q;
		end else begin
			case (tok_in.op)
				oil_pkg::OP_INSERT: begin
					if (held) begin
						if (tok_in.flag) begin
							// ripple the displaced entry one place on
							main_d     = tok_in.data;
							tok_d.data = main_q;
						end else if (!(main_q < tok_in.value)) begin
							main_d     = tok_in.value;
							tok_d.data = main_q;
							tok_d.flag = 1'b1;
						end
					end else if (slot) begin
						main_d     = tok_in.flag ? tok_in.data : tok_in.value;
						tok_d.flag = 1'b1;
					end
				end
				oil_pkg::OP_CONTAINS: begin
					if (held && (main_q == tok_in.value)) begin
						tok_d.flag = 1'b1;
					end
				end
				oil_pkg::OP_GET: begin
					if (held && at_pos) begin
						tok_d.flag = 1'b1;
						tok_d.data = main_q;
					end
				end
				oil_pkg::OP_REMOVE: begin
					// right neighbour is not yet touched by the token
					if (held && (oil_pkg::CMP_W'(tok_in.idx) >= oil_pkg::CMP_W'(tok_in.pos))) begin
						main_d = main_right;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		main_q <= main_d;
		aux_q  <= aux_d;
	end

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out  = tok_q;
	assign main_out = main_q;
	assign aux_out  = aux_q;

endmodule

// ----- hw/rtl/oil_checker.sv -----
module oil_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [oil_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int ST_LO = oil_pkg::DATA_W + 1;

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// one word in flight: input closes after each accepted word
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is being worked on");

	// position past end never reports found
	a_past_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[ST_LO +: oil_pkg::STAT_W] == oil_pkg::STAT_PAST)
		|-> !m_tdata[oil_pkg::DATA_W])
		else $error("found set with position past end");

	// reserved status code never appears, and a dropped insert reads zero
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ST_LO +: oil_pkg::STAT_W] != oil_pkg::STAT_RSVD) &&
		((m_tdata[ST_LO +: oil_pkg::STAT_W] != oil_pkg::STAT_FULL) ||
		 ((m_tdata[oil_pkg::DATA_W-1:0] == '0) && !m_tdata[oil_pkg::DATA_W])))
		else $error("bad status or payload on result word");

endmodule

bind ordered_integer_list_unit oil_checker u_oil_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
